// ===== sv/lrid_pkg.sv =====
// ----------------------------------------------------------------------------
// lrid_pkg
// Shared types and constants for the LZW + RLE image decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package lrid_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_PUSH  = 2'd1;
  localparam logic [1:0] FUNC_PULL  = 2'd2;

  localparam logic [1:0] ST_PIXEL = 2'd0;
  localparam logic [1:0] ST_MORE  = 2'd1;
  localparam logic [1:0] ST_ACC   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [7:0] RLE_ESC = 8'h90;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXPAND,
    S_STRRD,
    S_STRUSE,
    S_DECODE,
    S_WALKRD,
    S_WALKUSE,
    S_ROOTUSE,
    S_ADDENT,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== sv/lrid_ram.sv =====
// ----------------------------------------------------------------------------
// lrid_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lrid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/lzw_rle_image_decoder.sv =====
// ----------------------------------------------------------------------------
// lzw_rle_image_decoder
// Pull-driven LZW (variable width, LSB first) decoder with 0x90 RLE expansion.
// ----------------------------------------------------------------------------
// Flow: start and push go straight to the response state; a pull answers
// from a pending run or held nibble directly, from a stored string byte via
// a string read, plus a read for each escape or count byte consumed first,
// and a new code walks the dictionary with one read per string byte.
// Throughput: one item at a time; the next item is taken only after the
// result leaves, when out_ready has cleared out_valid.
// Reset: synchronous active-low rst_n clears all control state; the RAMs are
// not cleared, roots 0..255 are formed by logic rather than stored.
`default_nettype none
module lzw_rle_image_decoder
  import lrid_pkg::*;
#(
  parameter int DICT_ENTRIES = 2048,
  parameter int STRING_DEPTH = 2048
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);
  localparam int DAW = $clog2(DICT_ENTRIES);
  localparam int SAW = $clog2(STRING_DEPTH);
  localparam int CW  = 13;  // code/counter width, holds 4096

  // Dictionary: {parent, byte}; string store of expanded string bytes
  logic           d_we;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [19:0]    d_wdata, d_rdata;
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [7:0]     s_wdata, s_rdata;

  lrid_ram #(.WIDTH(20), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata));
  lrid_ram #(.WIDTH(8), .DEPTH(STRING_DEPTH)) u_str (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));

  state_t state_r, state_nxt;

  logic [31:0]   buf_r;
  logic [5:0]    fill_r;
  logic          nib_mode_r;
  logic [3:0]    wlim_r, cw_r;
  logic [CW-1:0] nfc_r, top_r, prev_r, len_r, pos_r, code_r, first_r;
  logic [7:0]    root_r, run_byte_r, run_left_r;
  logic          esc_r;
  logic [4:0]    held_r;
  logic [1:0]    func_r;
  logic [7:0]    din_r;
  out_item_t     res_r;
  logic          ovalid_r;

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  // current code extraction
  logic [11:0] cmask, new_code;
  assign cmask    = 12'((13'd1 << cw_r) - 13'd1);
  assign new_code = buf_r[11:0] & cmask;

  // emit one expanded byte: nibble split
  function automatic out_item_t emit(input logic [7:0] b, input logic nm);
    out_item_t r;
    r.status = ST_PIXEL;
    r.pixel  = nm ? {4'd0, b[3:0]} : b;
    return r;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = (in_data.func == FUNC_PULL) ? S_EXPAND : S_RESP;
        end
      end
      S_EXPAND: begin
        if (nib_mode_r && held_r[4])        state_nxt = S_RESP;
        else if (run_left_r != 8'd0)       state_nxt = S_RESP;
        else if (pos_r != '0)              state_nxt = S_STRRD;
        else if ({7'd0, fill_r} < {9'd0, cw_r}) state_nxt = S_RESP;
        else                               state_nxt = S_DECODE;
      end
      S_STRRD:  state_nxt = S_STRUSE;
      S_STRUSE: begin
        if (esc_r) state_nxt = (s_rdata == 8'd0) ? S_RESP : S_EXPAND;
        else       state_nxt = (s_rdata == RLE_ESC) ? S_EXPAND : S_RESP;
      end
      S_DECODE: state_nxt = S_WALKRD;
      S_WALKRD: state_nxt = (code_r >= CW'(DICT_ENTRIES)) ? S_ADDENT :
                            (code_r < CW'(256)) ? S_ROOTUSE :
                            (len_r >= CW'(STRING_DEPTH)) ? S_ROOTUSE : S_WALKUSE;
      S_WALKUSE: state_nxt = S_WALKRD;
      S_ROOTUSE: state_nxt = S_ADDENT;
      S_ADDENT:  state_nxt = S_EXPAND;
      S_RESP:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    d_we = 1'b0; d_waddr = nfc_r[DAW-1:0];
    d_wdata = {prev_r[11:0], root_r};
    d_raddr = code_r[DAW-1:0];
    s_we = 1'b0; s_waddr = len_r[SAW-1:0]; s_wdata = root_r;
    s_raddr = SAW'(pos_r - CW'(1));
    unique case (state_r)
      S_DECODE: begin
        // KwKwK: store root first
        s_we    = ({1'b0, new_code} >= nfc_r);
        s_waddr = '0;
      end
      S_WALKUSE: begin
        s_we = 1'b1; s_wdata = d_rdata[7:0];
      end
      S_ROOTUSE: begin
        s_we = (len_r < CW'(STRING_DEPTH));
        s_wdata = (code_r < CW'(256)) ? code_r[7:0] : d_rdata[7:0];
      end
      S_ADDENT: d_we = (nfc_r < CW'(DICT_ENTRIES));
      default: ;
    endcase
  end

  logic [7:0] rootv;
  assign rootv = (code_r < CW'(256)) ? code_r[7:0] : d_rdata[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0;
      buf_r <= '0; fill_r <= '0; nib_mode_r <= 1'b0; wlim_r <= 4'd12;
      cw_r <= 4'd9; nfc_r <= CW'(256); top_r <= CW'(511); prev_r <= '0;
      root_r <= '0; len_r <= '0; pos_r <= '0; run_byte_r <= '0;
      run_left_r <= '0; esc_r <= 1'b0; held_r <= '0; code_r <= '0;
      first_r <= '0; func_r <= '0; din_r <= '0; res_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            func_r <= in_data.func; din_r <= in_data.data_byte;
            res_r  <= '{pixel: 8'd0, status: ST_MORE};
          end
        end
        S_EXPAND: begin
          if (nib_mode_r && held_r[4]) begin
            res_r  <= '{pixel: {4'd0, held_r[3:0]}, status: ST_PIXEL};
            held_r <= '0;
          end else if (run_left_r != 8'd0) begin
            run_left_r <= run_left_r - 8'd1;
            res_r <= emit(run_byte_r, nib_mode_r);
            if (nib_mode_r) held_r <= {1'b1, run_byte_r[7:4]};
          end else if (pos_r == '0 && ({7'd0, fill_r} < {9'd0, cw_r})) begin
            res_r <= '{pixel: 8'd0, status: ST_MORE};
          end
        end
        S_STRRD: begin
          // read address is taken from the old position this cycle
          pos_r <= pos_r - CW'(1);
        end
        S_STRUSE: begin
          if (esc_r) begin
            esc_r <= 1'b0;
            if (s_rdata == 8'd0) begin
              run_byte_r <= RLE_ESC;
              res_r <= emit(RLE_ESC, nib_mode_r);
              if (nib_mode_r) held_r <= {1'b1, RLE_ESC[7:4]};
            end else begin
              run_left_r <= s_rdata - 8'd1;
            end
          end else if (s_rdata == RLE_ESC) begin
            esc_r <= 1'b1;
          end else begin
            run_byte_r <= s_rdata;
            res_r <= emit(s_rdata, nib_mode_r);
            if (nib_mode_r) held_r <= {1'b1, s_rdata[7:4]};
          end
        end
        S_DECODE: begin
          buf_r   <= buf_r >> cw_r;
          fill_r  <= fill_r - {2'd0, cw_r};
          first_r <= {1'b0, new_code};
          if ({1'b0, new_code} >= nfc_r) begin
            len_r <= CW'(1); code_r <= prev_r;
          end else begin
            len_r <= '0; code_r <= {1'b0, new_code};
          end
        end
        S_WALKRD: begin
          if (code_r >= CW'(DICT_ENTRIES)) root_r <= '0;
        end
        S_WALKUSE: begin
          len_r  <= len_r + CW'(1);
          code_r <= {1'b0, d_rdata[19:8]};
        end
        S_ROOTUSE: begin
          root_r <= rootv;
          if (len_r < CW'(STRING_DEPTH)) len_r <= len_r + CW'(1);
        end
        S_ADDENT: begin
          logic [CW-1:0] n;
          n = (nfc_r < CW'(DICT_ENTRIES)) ? nfc_r + CW'(1) : nfc_r;
          nfc_r <= n;
          if (n > top_r) begin
            if (cw_r + 4'd1 > wlim_r) begin
              cw_r <= 4'd9; nfc_r <= CW'(256); top_r <= CW'(511);
            end else begin
              cw_r  <= cw_r + 4'd1;
              top_r <= CW'((13'd1 << (cw_r + 4'd1)) - 13'd1);
            end
          end
          prev_r <= first_r;
          pos_r  <= len_r;
        end
        S_RESP: begin
          ovalid_r <= 1'b1;
          if (func_r == FUNC_START) begin
            logic [7:0] lim;
            lim = din_r[7] ? (8'd0 - din_r) : din_r;
            nib_mode_r <= !din_r[7];
            wlim_r <= (lim < 8'd9) ? 4'd9 : (lim > 8'd12) ? 4'd12 : lim[3:0];
            cw_r <= 4'd9; nfc_r <= CW'(256); top_r <= CW'(511);
            buf_r <= '0; fill_r <= '0; prev_r <= '0; root_r <= '0;
            len_r <= '0; pos_r <= '0; run_byte_r <= '0; run_left_r <= '0;
            esc_r <= 1'b0; held_r <= '0;
            res_r <= '{pixel: 8'd0, status: ST_ACC};
          end else if (func_r == FUNC_PUSH) begin
            if (fill_r > 6'd24) begin
              res_r <= '{pixel: 8'd0, status: ST_FULL};
            end else begin
              buf_r  <= buf_r | ({24'd0, din_r} << fill_r);
              fill_r <= fill_r + 6'd8;
              res_r  <= '{pixel: 8'd0, status: ST_ACC};
            end
          end else if (func_r != FUNC_PULL) begin
            res_r <= '{pixel: 8'd0, status: ST_ACC};
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
